/* sv/lsc_pkg.sv */
// shared types and constants for the line segment window clipper
// no dependencies; imported by every module of the block
`default_nettype none

package lsc_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // clip status codes
  localparam logic [1:0] STATUS_INSIDE  = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED = 2'd1;
  localparam logic [1:0] STATUS_REJECT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  // control that travels beside the coordinates through the pipeline
  typedef struct packed {
    logic       valid;
    logic       reject;
    logic [1:0] status;
    logic       neg_x;
    logic       neg_y;
  } lsc_ctl_t;

endpackage

`default_nettype wire

/* sv/lsc_div_cell.sv */
// one restoring-division cell: retires one quotient bit per cycle while ce is high
// depends on lsc_pkg for the default of W (COORD_WIDTH_DEF)
`default_nettype none

module lsc_div_cell
  import lsc_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         ce,
  input  wire logic [W:0]   rem_in,
  input  wire logic [W-1:0] low_in,
  input  wire logic [W:0]   den_in,
  output logic      [W:0]   rem_out,
  output logic      [W-1:0] low_out,
  output logic      [W:0]   den_out
);

  logic [W+1:0] trial;
  logic [W+1:0] diff;
  logic         take;

  always_comb begin
    trial = {rem_in, low_in[W-1]};
    diff  = trial - {1'b0, den_in};
    take  = (trial >= {1'b0, den_in});
  end

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_out <= take ? diff[W:0] : trial[W:0];
      low_out <= {low_in[W-2:0], take};
      den_out <= den_in;
    end
  end

endmodule

`default_nettype wire

/* sv/lsc_front.sv */
// front end: edge distances, entry/exit parameter selection and the
// reject test, four register stages; depends on lsc_pkg
`default_nettype none

module lsc_front
  import lsc_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   ce,
  input  wire logic                   in_valid,
  input  wire logic signed [W-1:0]    start_x,
  input  wire logic signed [W-1:0]    start_y,
  input  wire logic signed [W-1:0]    end_x,
  input  wire logic signed [W-1:0]    end_y,
  input  wire logic signed [W-1:0]    x_min,
  input  wire logic signed [W-1:0]    y_min,
  input  wire logic signed [W-1:0]    x_max,
  input  wire logic signed [W-1:0]    y_max,
  output lsc_ctl_t                    ctl,
  output logic signed [W-1:0]         sx_o,
  output logic signed [W-1:0]         sy_o,
  output logic [3:0][2*W:0]           num,
  output logic [1:0][W:0]             den
);

  // stage 1
  logic signed [W:0]   dx, dy, n1x_c, n1y_c, n2x_c, n2y_c;
  logic                rej_c;
  logic                v1, rej1, zx1, zy1, negx1, negy1;
  logic [W-1:0]        denx1, deny1;
  logic signed [W:0]   n1x1, n1y1, n2x1, n2y1;
  logic signed [W-1:0] sx1, sy1;

  always_comb begin
    dx    = $signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x});
    dy    = $signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y});
    n1x_c = (dx > 0) ? $signed({x_min[W-1], x_min}) - $signed({start_x[W-1], start_x})
                     : $signed({start_x[W-1], start_x}) - $signed({x_max[W-1], x_max});
    n2x_c = (dx > 0) ? $signed({x_max[W-1], x_max}) - $signed({start_x[W-1], start_x})
                     : $signed({start_x[W-1], start_x}) - $signed({x_min[W-1], x_min});
    n1y_c = (dy > 0) ? $signed({y_min[W-1], y_min}) - $signed({start_y[W-1], start_y})
                     : $signed({start_y[W-1], start_y}) - $signed({y_max[W-1], y_max});
    n2y_c = (dy > 0) ? $signed({y_max[W-1], y_max}) - $signed({start_y[W-1], start_y})
                     : $signed({start_y[W-1], start_y}) - $signed({y_min[W-1], y_min});
    // parallel to an edge and beyond it
    rej_c = ((dx == 0) && ((start_x < x_min) || (start_x > x_max)))
         || ((dy == 0) && ((start_y < y_min) || (start_y > y_max)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rej1  <= rej_c;
      zx1   <= (dx == 0);
      zy1   <= (dy == 0);
      negx1 <= dx[W];
      negy1 <= dy[W];
      denx1 <= dx[W] ? W'(-dx) : dx[W-1:0];
      deny1 <= dy[W] ? W'(-dy) : dy[W-1:0];
      n1x1  <= n1x_c;
      n1y1  <= n1y_c;
      n2x1  <= n2x_c;
      n2y1  <= n2y_c;
      sx1   <= start_x;
      sy1   <= start_y;
    end
  end

  // stage 2: candidate checks and cross products
  logic                  v2, rej2, negx2, negy2, v1x2, v1y2, v2x2, v2y2;
  logic [W-1:0]          denx2, deny2;
  logic signed [W:0]     n1x2, n1y2, n2x2, n2y2;
  logic signed [W-1:0]   sx2, sy2;
  logic signed [2*W+1:0] c1a, c1b, c2a, c2b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rej2  <= rej1;
      negx2 <= negx1;
      negy2 <= negy1;
      v1x2  <= !zx1 && (n1x1 > 0);
      v1y2  <= !zy1 && (n1y1 > 0);
      v2x2  <= !zx1 && (n2x1 < $signed({1'b0, denx1}));
      v2y2  <= !zy1 && (n2y1 < $signed({1'b0, deny1}));
      denx2 <= denx1;
      deny2 <= deny1;
      n1x2  <= n1x1;
      n1y2  <= n1y1;
      n2x2  <= n2x1;
      n2y2  <= n2y1;
      sx2   <= sx1;
      sy2   <= sy1;
      c1a   <= n1x1 * $signed({1'b0, deny1});
      c1b   <= n1y1 * $signed({1'b0, denx1});
      c2a   <= n2x1 * $signed({1'b0, deny1});
      c2b   <= n2y1 * $signed({1'b0, denx1});
    end
  end

  // stage 3: latest entry and earliest exit
  logic              sel1x, sel1y, sel2x, sel2y;
  logic              v3, rej3, negx3, negy3;
  logic [1:0]        status3;
  logic signed [W:0] t1n3, t2n3;
  logic [W-1:0]      t1d3, t2d3, denx3, deny3;
  logic signed [W-1:0] sx3, sy3;

  always_comb begin
    sel1y = v1y2 && (!v1x2 || (c1b > c1a));
    sel1x = v1x2 && !sel1y;
    sel2y = v2y2 && (!v2x2 || (c2b < c2a));
    sel2x = v2x2 && !sel2y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rej3    <= rej2;
      negx3   <= negx2;
      negy3   <= negy2;
      status3 <= (sel1x || sel1y || sel2x || sel2y) ? STATUS_CLIPPED : STATUS_INSIDE;
      t1n3    <= sel1y ? n1y2 : (sel1x ? n1x2 : '0);
      t1d3    <= sel1y ? deny2 : (sel1x ? denx2 : W'(1));
      t2n3    <= sel2y ? n2y2 : (sel2x ? n2x2 : (W+1)'(1));
      t2d3    <= sel2y ? deny2 : (sel2x ? denx2 : W'(1));
      denx3   <= denx2;
      deny3   <= deny2;
      sx3     <= sx2;
      sy3     <= sy2;
    end
  end

  // stage 4: entry-after-exit products and offset products
  logic                  v4, rej4, negx4, negy4;
  logic [1:0]            status4;
  logic signed [2*W+1:0] g1, g2;
  logic [2*W-1:0]        p1x, p1y, p2x, p2y;
  logic [W-1:0]          t1d4, t2d4;
  logic signed [W-1:0]   sx4, sy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rej4    <= rej3;
      negx4   <= negx3;
      negy4   <= negy3;
      status4 <= status3;
      g1      <= t1n3 * $signed({1'b0, t2d3});
      g2      <= t2n3 * $signed({1'b0, t1d3});
      p1x     <= {{W{1'b0}}, t1n3[W-1:0]} * {{W{1'b0}}, denx3};
      p1y     <= {{W{1'b0}}, t1n3[W-1:0]} * {{W{1'b0}}, deny3};
      p2x     <= {{W{1'b0}}, t2n3[W-1:0]} * {{W{1'b0}}, denx3};
      p2y     <= {{W{1'b0}}, t2n3[W-1:0]} * {{W{1'b0}}, deny3};
      t1d4    <= t1d3;
      t2d4    <= t2d3;
      sx4     <= sx3;
      sy4     <= sy3;
    end
  end

  // round to nearest: floor((2*prod + den) / (2*den))
  always_comb begin
    ctl.valid  = v4;
    ctl.reject = rej4 || (g1 > g2);
    ctl.status = status4;
    ctl.neg_x  = negx4;
    ctl.neg_y  = negy4;
    sx_o       = sx4;
    sy_o       = sy4;
    num[0]     = {p1x, 1'b0} + {{(W+1){1'b0}}, t1d4};
    num[1]     = {p1y, 1'b0} + {{(W+1){1'b0}}, t1d4};
    num[2]     = {p2x, 1'b0} + {{(W+1){1'b0}}, t2d4};
    num[3]     = {p2y, 1'b0} + {{(W+1){1'b0}}, t2d4};
    den[0]     = {t1d4, 1'b0};
    den[1]     = {t2d4, 1'b0};
  end

endmodule

`default_nettype wire

/* sv/line_segment_window_clipper.sv */
// top level of the line segment window clipper: window registers, front end,
// four lanes of division cells and the output register; uses lsc_pkg,
// lsc_front and lsc_div_cell
//
// channel   | direction | payload
// ----------+-----------+----------------------------------------------
// s_axis    | in        | tdata: start_x, start_y, end_x, end_y
// m_axis    | out       | tuser: clip_status; tdata: entry/exit points
// cfg       | in        | cfg_index, cfg_data (window edges)
//
// one segment per cycle unless stalled by m_tready; a segment passes the
// front end stages, a division cell per quotient bit and the output register
// rst is synchronous and clears the valid flags and the window to 0,0,639,479
// the whole pipeline halts while a finished word waits on m_tready low
`default_nettype none

module line_segment_window_clipper
  import lsc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_BITS  = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_BITS-1:0]     s_tdata,   // start_x, start_y, end_x, end_y
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [IN_BITS-1:0]          m_tdata,   // entry_x, entry_y, exit_x, exit_y
  output logic [7:0]                  m_tuser,   // clip_status
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] x_min, y_min, x_max, y_max;
  logic                ce;

  assign cfg_ready = 1'b1;
  assign ce        = !m_tvalid || m_tready;
  assign s_tready  = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0;
      y_min <= '0;
      x_max <= W'(639);
      y_max <= W'(479);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_MIN: x_min <= cfg_data;
        REG_Y_MIN: y_min <= cfg_data;
        REG_X_MAX: x_max <= cfg_data;
        REG_Y_MAX: y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  lsc_ctl_t            f_ctl;
  logic signed [W-1:0] f_sx, f_sy;
  logic [3:0][2*W:0]   f_num;
  logic [1:0][W:0]     f_den;

  lsc_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .start_x  (s_tdata[W-1:0]),
    .start_y  (s_tdata[2*W-1:W]),
    .end_x    (s_tdata[3*W-1:2*W]),
    .end_y    (s_tdata[4*W-1:3*W]),
    .x_min    (x_min),
    .y_min    (y_min),
    .x_max    (x_max),
    .y_max    (y_max),
    .ctl      (f_ctl),
    .sx_o     (f_sx),
    .sy_o     (f_sy),
    .num      (f_num),
    .den      (f_den)
  );

  // division lanes: entry x, entry y, exit x, exit y
  logic [W:0]   rem_c [4][W+1];
  logic [W-1:0] low_c [4][W+1];
  logic [W:0]   den_c [4][W+1];

  for (genvar ln = 0; ln < 4; ln++) begin : g_lane
    assign rem_c[ln][0] = f_num[ln][2*W:W];
    assign low_c[ln][0] = f_num[ln][W-1:0];
    assign den_c[ln][0] = f_den[ln/2];
    for (genvar c = 0; c < W; c++) begin : g_cell
      lsc_div_cell #(.W(W)) u_cell (
        .clk     (clk),
        .ce      (ce),
        .rem_in  (rem_c[ln][c]),
        .low_in  (low_c[ln][c]),
        .den_in  (den_c[ln][c]),
        .rem_out (rem_c[ln][c+1]),
        .low_out (low_c[ln][c+1]),
        .den_out (den_c[ln][c+1])
      );
    end
  end

  // side data keeps pace with the cells
  lsc_ctl_t            sd_ctl [W];
  logic signed [W-1:0] sd_sx  [W];
  logic signed [W-1:0] sd_sy  [W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < W; i++) sd_ctl[i].valid <= 1'b0;
    end else if (ce) begin
      sd_ctl[0] <= f_ctl;
      sd_sx[0]  <= f_sx;
      sd_sy[0]  <= f_sy;
      for (int i = 1; i < W; i++) begin
        sd_ctl[i] <= sd_ctl[i-1];
        sd_sx[i]  <= sd_sx[i-1];
        sd_sy[i]  <= sd_sy[i-1];
      end
    end
  end

  lsc_ctl_t   lc;
  logic [W-1:0] ent_x, ent_y, ext_x, ext_y;

  always_comb begin
    lc    = sd_ctl[W-1];
    ent_x = lc.neg_x ? sd_sx[W-1] - low_c[0][W] : sd_sx[W-1] + low_c[0][W];
    ent_y = lc.neg_y ? sd_sy[W-1] - low_c[1][W] : sd_sy[W-1] + low_c[1][W];
    ext_x = lc.neg_x ? sd_sx[W-1] - low_c[2][W] : sd_sx[W-1] + low_c[2][W];
    ext_y = lc.neg_y ? sd_sy[W-1] - low_c[3][W] : sd_sy[W-1] + low_c[3][W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= lc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tuser <= {6'd0, lc.reject ? STATUS_REJECT : lc.status};
      m_tdata <= lc.reject ? '0 : IN_BITS'({ext_y, ext_x, ent_y, ent_x});
    end
  end

endmodule

`default_nettype wire
